// ===== hw/rtl/rti_pkg.sv =====
`default_nettype none
package rti_pkg;

	localparam int CW   = 21;             // coordinate width, signed Q10.10
	localparam int TW   = 16;             // texture coordinate width, unsigned Q1.15
	localparam int TF   = 16;             // fraction bits of the hit distance
	localparam int TVW  = 32;             // hit distance width
	localparam int XW   = 3 * CW;         // packed vertex register width
	localparam int TXW  = 32;             // packed texture register width
	localparam int THW  = 20;             // parallel threshold width
	localparam int PDW  = 64;             // APB data width
	localparam int AL   = 3;              // byte address bits below the register index
	localparam int AW   = AL + 3;         // APB address width

	localparam int EW   = CW + 1;         // edge and origin offset width
	localparam int PW   = 2 * EW + 1;     // cross product component width
	localparam int SPL  = EW;             // split point of a cross product component
	localparam int DW   = EW + PW + 3;    // dot product width
	localparam int QB   = TVW + 1;        // quotient bits of t, top bit flags overflow
	localparam int RW   = DW + QB;        // remainder width of the t divider
	localparam int TCH  = 23;             // chunk of a barycentric weight per multiplier
	localparam int TPW  = TW + TCH;       // texture partial product width
	localparam int ACW  = TW + DW + 2;    // texture accumulator width
	localparam int MW   = TVW + CW;       // t times direction width

	localparam int ST_DIV  = 12;          // first divider stage
	localparam int ST_POST = ST_DIV + QB; // stage after the divider
	localparam int NS      = ST_POST + 2; // total pipeline stages

	typedef logic signed [CW-1:0]  coord_t;
	typedef logic signed [TVW-1:0] tval_t;
	typedef logic [TW-1:0]         tex_t;

	localparam tval_t  TMAX = {1'b0, {(TVW-1){1'b1}}};
	localparam tval_t  TMIN = {1'b1, {(TVW-1){1'b0}}};
	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [AW-AL-1:0] {
		REG_V0_XYZ = 3'd0,
		REG_V1_XYZ = 3'd1,
		REG_V2_XYZ = 3'd2,
		REG_V0_TEX = 3'd3,
		REG_V1_TEX = 3'd4,
		REG_V2_TEX = 3'd5,
		REG_THRESH = 3'd6
	} reg_idx_t;

	typedef struct packed {
		coord_t [2:0] org;
		coord_t [2:0] dir;
		tval_t        near_l;
		tval_t        far_l;
	} ray_t;

	typedef struct packed {
		logic [RW-1:0]          r;
		logic [QB-1:0]          q;
		logic [1:0][ACW-1:0]    tr;
		logic [1:0][TW-1:0]     tq;
		logic [DW-1:0]          a;
		logic                   negt;
		logic                   hit;
		ray_t                   ray;
	} div_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rti_if.sv =====
`default_nettype none
interface rti_ray_if;
	import rti_pkg::*;
	logic   valid;
	logic   ready;
	coord_t origin_x;
	coord_t origin_y;
	coord_t origin_z;
	coord_t direction_x;
	coord_t direction_y;
	coord_t direction_z;
	tval_t  near_limit;
	tval_t  far_limit;
	modport source (output valid, origin_x, origin_y, origin_z, direction_x, direction_y,
		direction_z, near_limit, far_limit, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, direction_x, direction_y,
		direction_z, near_limit, far_limit, output ready);
endinterface

interface rti_hit_if;
	import rti_pkg::*;
	logic   valid;
	logic   ready;
	logic   hit_found;
	tval_t  distance;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;
	tex_t   tex_u;
	tex_t   tex_v;
	modport source (output valid, hit_found, distance, point_x, point_y, point_z, tex_u,
		tex_v, input ready);
	modport sink (input valid, hit_found, distance, point_x, point_y, point_z, tex_u,
		tex_v, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ray_triangle_intersect.sv =====
// Ray / triangle intersection, Moller-Trumbore test in exact fixed point.
// The triangle (three packed Q10.10 vertices, per-vertex texture u/v and the
// parallel threshold) sits in APB registers at byte address 8*index; write
// them only while no ray is in flight. Rays enter on the ray channel, one
// result per ray leaves on the hit channel, in order. A miss returns
// hit_found = 0 with every other field 0.
// Throughput: one ray per cycle unless the hit channel stalls. A ray passes
// eleven stages of edges, cross and dot products (dot products in split 22x23
// multipliers), tests and texture products, the 33-step restoring divider for
// t (one quotient bit per stage) and three stages of clamp, window test and hit
// point. The texture division runs in the first 16 divider stages.
// Each stage holds its item while the stage after it is full and stalled,
// so a stalled receiver backs up only the filled stages; bubbles collapse
// and a new ray is taken as long as any stage downstream can advance.
// Reset clears all valid bits and loads the registers with their defaults
// (vertices and texture 0, parallel threshold 1).
`default_nettype none
module ray_triangle_intersect (
	input  logic                     clk,
	input  logic                     arst_n,
	rti_ray_if.sink                  ray,
	rti_hit_if.source                hit,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [rti_pkg::AW-1:0]   paddr,
	input  logic [rti_pkg::PDW-1:0]  pwdata,
	output logic [rti_pkg::PDW-1:0]  prdata,
	output logic                     pready
);
	import rti_pkg::*;

	// ---------------- configuration registers ----------------
	logic [XW-1:0]  vxyz_q [3];
	logic [TXW-1:0] vtex_q [3];
	logic [THW-1:0] thr_q;
	reg_idx_t       ridx;

	assign ridx   = reg_idx_t'(paddr[AW-1:AL]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				vxyz_q[i] <= '0;
				vtex_q[i] <= '0;
			end
			thr_q <= THW'(1);
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_V0_XYZ: vxyz_q[0] <= pwdata[XW-1:0];
				REG_V1_XYZ: vxyz_q[1] <= pwdata[XW-1:0];
				REG_V2_XYZ: vxyz_q[2] <= pwdata[XW-1:0];
				REG_V0_TEX: vtex_q[0] <= pwdata[TXW-1:0];
				REG_V1_TEX: vtex_q[1] <= pwdata[TXW-1:0];
				REG_V2_TEX: vtex_q[2] <= pwdata[TXW-1:0];
				REG_THRESH: thr_q     <= pwdata[THW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_V0_XYZ: prdata = PDW'(vxyz_q[0]);
			REG_V1_XYZ: prdata = PDW'(vxyz_q[1]);
			REG_V2_XYZ: prdata = PDW'(vxyz_q[2]);
			REG_V0_TEX: prdata = PDW'(vtex_q[0]);
			REG_V1_TEX: prdata = PDW'(vtex_q[1]);
			REG_V2_TEX: prdata = PDW'(vtex_q[2]);
			REG_THRESH: prdata = PDW'(thr_q);
			default:    prdata = '0;
		endcase
	end

	// Unpack vertex coordinates (x in low bits) and texture halves (u low).
	coord_t vc [3][3];
	tex_t   tx [2][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				vc[i][j] = vxyz_q[i][j*CW +: CW];
			end
			for (int c = 0; c < 2; c++) begin
				tx[c][i] = vtex_q[i][c*TW +: TW];
			end
		end
	end

	// ---------------- handshake: valid chain with per-stage hold ----------------
	logic [NS+1:1] en;
	logic [NS:1]   vld_s;
	logic [NS:1]   vin;

	assign en[NS+1] = hit.ready;
	for (genvar k = 1; k <= NS; k++) begin : g_en
		// A stage advances when it is empty or the next stage advances.
		assign en[k] = !vld_s[k] || en[k+1];
	end
	assign ray.ready = en[1];
	assign vin       = {vld_s[NS-1:1], ray.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vin[k];
				end
			end
		end
	end

	// ---------------- stage 1: edges and origin offset ----------------
	ray_t                  ray_in;
	logic signed [EW-1:0]  e1_s1 [3];
	logic signed [EW-1:0]  e2_s1 [3];
	logic signed [EW-1:0]  sv_s1 [3];
	ray_t                  ray_s1;

	always_comb begin
		ray_in.org[0] = ray.origin_x;
		ray_in.org[1] = ray.origin_y;
		ray_in.org[2] = ray.origin_z;
		ray_in.dir[0] = ray.direction_x;
		ray_in.dir[1] = ray.direction_y;
		ray_in.dir[2] = ray.direction_z;
		ray_in.near_l = ray.near_limit;
		ray_in.far_l  = ray.far_limit;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int j = 0; j < 3; j++) begin
				e1_s1[j] <= EW'(vc[1][j]) - EW'(vc[0][j]);
				e2_s1[j] <= EW'(vc[2][j]) - EW'(vc[0][j]);
				sv_s1[j] <= EW'(coord_t'(ray_in.org[j])) - EW'(vc[0][j]);
			end
			ray_s1 <= ray_in;
		end
	end

	// ---------------- stages 2-3: h = dir x e2, q = s x e1 ----------------
	logic signed [PW-1:0]  ph_s2 [3][2];
	logic signed [PW-1:0]  pq_s2 [3][2];
	logic signed [EW-1:0]  e1_s2 [3];
	logic signed [EW-1:0]  e2_s2 [3];
	logic signed [EW-1:0]  sv_s2 [3];
	ray_t                  ray_s2;

	for (genvar j = 0; j < 3; j++) begin : g_cross
		localparam int JA = (j + 1) % 3;
		localparam int JB = (j + 2) % 3;
		always_ff @(posedge clk) begin
			if (en[2]) begin
				ph_s2[j][0] <= PW'(coord_t'(ray_s1.dir[JA])) * PW'(e2_s1[JB]);
				ph_s2[j][1] <= PW'(coord_t'(ray_s1.dir[JB])) * PW'(e2_s1[JA]);
				pq_s2[j][0] <= PW'(sv_s1[JA]) * PW'(e1_s1[JB]);
				pq_s2[j][1] <= PW'(sv_s1[JB]) * PW'(e1_s1[JA]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			e1_s2  <= e1_s1;
			e2_s2  <= e2_s1;
			sv_s2  <= sv_s1;
			ray_s2 <= ray_s1;
		end
	end

	logic signed [PW-1:0]  h_s3 [3];
	logic signed [PW-1:0]  q_s3 [3];
	logic signed [EW-1:0]  e1_s3 [3];
	logic signed [EW-1:0]  e2_s3 [3];
	logic signed [EW-1:0]  sv_s3 [3];
	ray_t                  ray_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int j = 0; j < 3; j++) begin
				h_s3[j] <= ph_s2[j][0] - ph_s2[j][1];
				q_s3[j] <= pq_s2[j][0] - pq_s2[j][1];
			end
			e1_s3  <= e1_s2;
			e2_s3  <= e2_s2;
			sv_s3  <= sv_s2;
			ray_s3 <= ray_s2;
		end
	end

	// ---------------- stages 4-6: a = e1.h, U = s.h, V = dir.q, N = e2.q ----------------
	// The wide operand is split at SPL: low part unsigned, high part signed.
	logic signed [EW-1:0]  dl [4][3];
	logic signed [PW-1:0]  dr [4][3];
	logic signed [PW-1:0]  plo_s4 [4][3];
	logic signed [PW-1:0]  phi_s4 [4][3];
	ray_t                  ray_s4;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dl[0][k] = e1_s3[k];
			dl[1][k] = sv_s3[k];
			dl[2][k] = EW'(coord_t'(ray_s3.dir[k]));
			dl[3][k] = e2_s3[k];
			dr[0][k] = h_s3[k];
			dr[1][k] = h_s3[k];
			dr[2][k] = q_s3[k];
			dr[3][k] = q_s3[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int d = 0; d < 4; d++) begin
				for (int k = 0; k < 3; k++) begin
					plo_s4[d][k] <= PW'(dl[d][k]) * PW'($signed({1'b0, dr[d][k][SPL-1:0]}));
					phi_s4[d][k] <= PW'(dl[d][k]) * PW'($signed(dr[d][k][PW-1:SPL]));
				end
			end
			ray_s4 <= ray_s3;
		end
	end

	logic signed [DW-1:0]  term_s5 [4][3];
	ray_t                  ray_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int d = 0; d < 4; d++) begin
				for (int k = 0; k < 3; k++) begin
					term_s5[d][k] <= (DW'(phi_s4[d][k]) <<< SPL) + DW'(plo_s4[d][k]);
				end
			end
			ray_s5 <= ray_s4;
		end
	end

	logic signed [DW-1:0]  dot_s6 [4];
	ray_t                  ray_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int d = 0; d < 4; d++) begin
				dot_s6[d] <= term_s5[d][0] + term_s5[d][1] + term_s5[d][2];
			end
			ray_s6 <= ray_s5;
		end
	end

	// ---------------- stage 7: make the determinant positive ----------------
	logic signed [DW-1:0]  ab_s7 [4];
	ray_t                  ray_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int d = 0; d < 4; d++) begin
				ab_s7[d] <= dot_s6[0][DW-1] ? -dot_s6[d] : dot_s6[d];
			end
			ray_s7 <= ray_s6;
		end
	end

	// ---------------- stage 8: parallel and barycentric tests ----------------
	logic signed [DW:0]    uv_sum;
	logic                  par_miss;
	logic                  bary_miss;
	logic                  hit_s8;
	logic [DW-1:0]         a_s8;
	logic [DW-1:0]         wt_s8 [3];
	logic [DW-1:0]         nab_s8;
	logic                  negt_s8;
	ray_t                  ray_s8;

	always_comb begin
		uv_sum    = (DW+1)'(ab_s7[1]) + (DW+1)'(ab_s7[2]);
		// Zero determinant is parallel even with a zero threshold.
		par_miss  = (ab_s7[0] == '0) || (ab_s7[0] < $signed(DW'(thr_q)));
		bary_miss = ab_s7[1][DW-1] || (ab_s7[0] < ab_s7[1]) || ab_s7[2][DW-1]
			|| ((DW+1)'(ab_s7[0]) < uv_sum);
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			hit_s8   <= !par_miss && !bary_miss;
			a_s8     <= ab_s7[0];
			wt_s8[0] <= ab_s7[0] - ab_s7[1] - ab_s7[2];
			wt_s8[1] <= ab_s7[1];
			wt_s8[2] <= ab_s7[2];
			negt_s8  <= ab_s7[3][DW-1];
			nab_s8   <= ab_s7[3][DW-1] ? -ab_s7[3] : ab_s7[3];
			ray_s8   <= ray_s7;
		end
	end

	// ---------------- stages 9-11: texture accumulators ----------------
	// Weights are nonnegative and below 2^69 on a hit; three chunks cover them.
	logic [TPW-1:0]        tp_s9 [2][3][3];
	logic [DW-1:0]         a_s9;
	logic [DW-1:0]         nab_s9;
	logic                  hit_s9;
	logic                  negt_s9;
	ray_t                  ray_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			for (int c = 0; c < 2; c++) begin
				for (int g = 0; g < 3; g++) begin
					for (int m = 0; m < 3; m++) begin
						tp_s9[c][g][m] <= TPW'(tx[c][g]) * TPW'(wt_s8[g][m*TCH +: TCH]);
					end
				end
			end
			a_s9    <= a_s8;
			nab_s9  <= nab_s8;
			hit_s9  <= hit_s8;
			negt_s9 <= negt_s8;
			ray_s9  <= ray_s8;
		end
	end

	logic [ACW-1:0]        tw_s10 [2][3];
	logic [DW-1:0]         a_s10;
	logic [DW-1:0]         nab_s10;
	logic                  hit_s10;
	logic                  negt_s10;
	ray_t                  ray_s10;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			for (int c = 0; c < 2; c++) begin
				for (int g = 0; g < 3; g++) begin
					tw_s10[c][g] <= ACW'(tp_s9[c][g][0])
						+ (ACW'(tp_s9[c][g][1]) << TCH)
						+ (ACW'(tp_s9[c][g][2]) << (2 * TCH));
				end
			end
			a_s10    <= a_s9;
			nab_s10  <= nab_s9;
			hit_s10  <= hit_s9;
			negt_s10 <= negt_s9;
			ray_s10  <= ray_s9;
		end
	end

	// div_s[0] is stage 11; div_s[k+1] is stage ST_DIV + k.
	div_t div_s [0:QB];

	always_ff @(posedge clk) begin
		if (en[ST_DIV-1]) begin
			div_s[0].r  <= RW'(nab_s10) << TF;
			div_s[0].q  <= '0;
			for (int c = 0; c < 2; c++) begin
				div_s[0].tr[c] <= tw_s10[c][0] + tw_s10[c][1] + tw_s10[c][2];
			end
			div_s[0].tq   <= '0;
			div_s[0].a    <= a_s10;
			div_s[0].negt <= negt_s10;
			div_s[0].hit  <= hit_s10;
			div_s[0].ray  <= ray_s10;
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	// t: top step flags a quotient of 2^32 or more; the rest build the bits.
	// Texture: quotient fits TW bits, so only the first TW steps work on it.
	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int TB = QB - 1 - k;
		div_t                 nx;
		logic [RW:0]          ts;
		logic [1:0][ACW-1:0]  trn;
		logic [1:0][TW-1:0]   tqn;

		if (k < TW) begin : g_tex
			localparam int XB = TW - 1 - k;
			logic [ACW:0] xs [2];
			always_comb begin
				trn = div_s[k].tr;
				tqn = div_s[k].tq;
				for (int c = 0; c < 2; c++) begin
					xs[c] = {1'b0, div_s[k].tr[c]} - {1'b0, ACW'(div_s[k].a) << XB};
					if (!xs[c][ACW]) begin
						trn[c]     = xs[c][ACW-1:0];
						tqn[c][XB] = 1'b1;
					end
				end
			end
		end else begin : g_pass
			assign trn = div_s[k].tr;
			assign tqn = div_s[k].tq;
		end

		always_comb begin
			nx    = div_s[k];
			ts    = {1'b0, div_s[k].r} - {1'b0, RW'(div_s[k].a) << TB};
			if (!ts[RW]) begin
				nx.r     = ts[RW-1:0];
				nx.q[TB] = 1'b1;
			end
			nx.tr = trn;
			nx.tq = tqn;
		end

		always_ff @(posedge clk) begin
			if (en[ST_DIV+k]) begin
				div_s[k+1] <= nx;
			end
		end
	end

	// ---------------- post stage 1: clamp t, window test ----------------
	div_t                  dq;
	logic                  sat;
	tval_t                 tq;
	logic                  win;
	logic                  hit_s45;
	tval_t                 tq_s45;
	logic [1:0][TW-1:0]    tex_s45;
	ray_t                  ray_s45;

	always_comb begin
		dq  = div_s[QB];
		sat = dq.q[QB-1] || (dq.negt ? (dq.q[TVW-1:0] > {1'b1, {(TVW-1){1'b0}}})
			: dq.q[TVW-1]);
		if (dq.negt) begin
			tq = sat ? TMIN : tval_t'(-dq.q[TVW-1:0]);
		end else begin
			tq = sat ? TMAX : tval_t'(dq.q[TVW-1:0]);
		end
		// A far limit of TMAX (the largest positive value) stands for no upper bound.
		win = (tq > tval_t'(dq.ray.near_l))
			&& ((tval_t'(dq.ray.far_l) == TMAX) || (tq < tval_t'(dq.ray.far_l)));
	end

	always_ff @(posedge clk) begin
		if (en[ST_POST]) begin
			hit_s45 <= dq.hit && win;
			tq_s45  <= tq;
			tex_s45 <= dq.tq;
			ray_s45 <= dq.ray;
		end
	end

	// ---------------- post stage 2: t * direction ----------------
	logic signed [MW-1:0]  pm_s46 [3];
	logic                  hit_s46;
	tval_t                 tq_s46;
	logic [1:0][TW-1:0]    tex_s46;
	coord_t [2:0]          org_s46;

	always_ff @(posedge clk) begin
		if (en[ST_POST+1]) begin
			for (int i = 0; i < 3; i++) begin
				pm_s46[i] <= MW'(tq_s45) * MW'(coord_t'(ray_s45.dir[i]));
			end
			hit_s46 <= hit_s45;
			tq_s46  <= tq_s45;
			tex_s46 <= tex_s45;
			org_s46 <= ray_s45.org;
		end
	end

	// ---------------- post stage 3: hit point, zero on miss, output register ----------------
	logic signed [MW:0]    ps [3];
	coord_t                pc [3];
	logic                  hit_s47;
	tval_t                 dist_s47;
	coord_t                pt_s47 [3];
	tex_t                  tu_s47;
	tex_t                  tv_s47;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// Arithmetic shift rounds toward minus infinity.
			ps[i] = (MW+1)'(pm_s46[i] >>> TF) + (MW+1)'(coord_t'(org_s46[i]));
			if (ps[i] > (MW+1)'(CMAX)) begin
				pc[i] = CMAX;
			end else if (ps[i] < (MW+1)'(CMIN)) begin
				pc[i] = CMIN;
			end else begin
				pc[i] = ps[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			hit_s47  <= hit_s46;
			dist_s47 <= hit_s46 ? tq_s46 : '0;
			for (int i = 0; i < 3; i++) begin
				pt_s47[i] <= hit_s46 ? pc[i] : '0;
			end
			tu_s47 <= hit_s46 ? tex_s46[0] : '0;
			tv_s47 <= hit_s46 ? tex_s46[1] : '0;
		end
	end

	assign hit.valid     = vld_s[NS];
	assign hit.hit_found = hit_s47;
	assign hit.distance  = dist_s47;
	assign hit.point_x   = pt_s47[0];
	assign hit.point_y   = pt_s47[1];
	assign hit.point_z   = pt_s47[2];
	assign hit.tex_u     = tu_s47;
	assign hit.tex_v     = tv_s47;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rti_pkg::*;

	localparam int STALL_LIMIT = 4000;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		coord_t org[3];
		coord_t dir[3];
		tval_t  near_l;
		tval_t  far_l;
	} ray_item_t;

	typedef struct {
		logic   hit;
		tval_t  hit_dist;
		coord_t pt[3];
		tex_t   tu;
		tex_t   tv;
	} hit_item_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [AW-1:0]  paddr;
	logic [PDW-1:0] pwdata, prdata;

	rti_ray_if ray_ch();
	rti_hit_if hit_ch();

	ray_triangle_intersect u_top (
		.clk(clk), .arst_n(arst_n), .ray(ray_ch), .hit(hit_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the triangle registers, updated at each APB write edge.
	logic [62:0] vert_reg[3];
	logic [31:0] tex_reg[3];
	logic [19:0] thresh_reg;

	ray_item_t ray_backlog[$];
	hit_item_t pending_hits[$];
	int   errors;
	int   idle_cycles;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// Moller-Trumbore test in exact wide integers against the shadow registers.
	function automatic hit_item_t predict_hit(ray_item_t r);
		hit_item_t res;
		wide_t  vt[3][3], e1[3], e2[3], s[3], d[3], h[3], q[3];
		wide_t  a, u, v, n, num, quo, w0, acc, tf;
		coord_t c;
		tex_t   f;
		longint tq, p;
		logic   negt;
		res.hit = 1'b0; res.hit_dist = '0; res.tu = '0; res.tv = '0;
		for (int i = 0; i < 3; i++) res.pt[i] = '0;
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++) begin
				c = vert_reg[k][i*CW +: CW];
				vt[k][i] = wide_t'(c);
			end
		for (int i = 0; i < 3; i++) begin
			e1[i] = vt[1][i] - vt[0][i];
			e2[i] = vt[2][i] - vt[0][i];
			s[i] = wide_t'(r.org[i]) - vt[0][i];
			d[i] = wide_t'(r.dir[i]);
		end
		h[0] = d[1]*e2[2] - d[2]*e2[1];
		h[1] = d[2]*e2[0] - d[0]*e2[2];
		h[2] = d[0]*e2[1] - d[1]*e2[0];
		q[0] = s[1]*e1[2] - s[2]*e1[1];
		q[1] = s[2]*e1[0] - s[0]*e1[2];
		q[2] = s[0]*e1[1] - s[1]*e1[0];
		a = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
		u = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
		v = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
		n = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
		if (a < 0) begin
			a = -a; u = -u; v = -v; n = -n;
		end
		// Parallel ray: zero determinant always misses, else compare to threshold
		if (a == 0 || a < wide_t'(thresh_reg)) return res;
		if (u < 0 || u > a || v < 0 || u + v > a) return res;
		num = n <<< TF;
		negt = num < 0;
		if (negt) num = -num;
		quo = num / a;
		if (negt) tq = (quo > 128'sh80000000) ? -64'sd2147483648 : -longint'(quo);
		else tq = (quo > 128'sh7FFFFFFF) ? 64'sd2147483647 : longint'(quo);
		// Open window; the top far value means no upper bound
		if (!(tq > longint'(r.near_l))) return res;
		if (r.far_l != TMAX && !(tq < longint'(r.far_l))) return res;
		res.hit = 1'b1;
		res.hit_dist = tval_t'(tq);
		for (int i = 0; i < 3; i++) begin
			p = longint'(r.org[i]) + ((tq * longint'(r.dir[i])) >>> TF);
			if (p > longint'(CMAX)) p = longint'(CMAX);
			if (p < longint'(CMIN)) p = longint'(CMIN);
			res.pt[i] = coord_t'(p);
		end
		w0 = a - u - v;
		for (int i = 0; i < 2; i++) begin
			acc = 0;
			f = tex_reg[0][i*TW +: TW]; tf = 0; tf[TW-1:0] = f; acc = acc + tf * w0;
			f = tex_reg[1][i*TW +: TW]; tf = 0; tf[TW-1:0] = f; acc = acc + tf * u;
			f = tex_reg[2][i*TW +: TW]; tf = 0; tf[TW-1:0] = f; acc = acc + tf * v;
			quo = acc / a;
			if (i == 0) res.tu = quo[TW-1:0];
			else res.tv = quo[TW-1:0];
		end
		return res;
	endfunction

	// Ray driver: bursts of random length separated by random gaps.
	ray_item_t cur_ray;
	int   burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		ray_item_t nxt;
		logic send;
		if (!arst_n) begin
			ray_ch.valid <= 1'b0;
			burst_left = 5;
			gap_left = 0;
		end else begin
			// Record the expectation of each accepted ray transaction
			if (ray_ch.valid && ray_ch.ready)
				pending_hits.push_back(predict_hit(cur_ray));
			if (!(ray_ch.valid && !ray_ch.ready)) begin
				send = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (ray_backlog.size() > 0) begin
					nxt = ray_backlog.pop_front();
					cur_ray = nxt;
					send = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
				ray_ch.valid <= send;
				if (send) begin
					ray_ch.origin_x <= nxt.org[0];
					ray_ch.origin_y <= nxt.org[1];
					ray_ch.origin_z <= nxt.org[2];
					ray_ch.direction_x <= nxt.dir[0];
					ray_ch.direction_y <= nxt.dir[1];
					ray_ch.direction_z <= nxt.dir[2];
					ray_ch.near_limit <= nxt.near_l;
					ray_ch.far_limit <= nxt.far_l;
				end
			end
		end
	end

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Result monitor: checks each result in order under a randomly chosen receiver stall pattern.
	int   cycle_cnt;
	int   stall_mode;
	always @(posedge clk or negedge arst_n) begin
		hit_item_t exp_h;
		logic rdy;
		if (!arst_n) begin
			hit_ch.ready <= 1'b0;
			cycle_cnt = 0;
			stall_mode = 0;
		end else begin
			if (hit_ch.valid && hit_ch.ready) begin
				if (pending_hits.size() == 0) begin
					$display("%0t: result with no ray outstanding", $time);
					errors++;
				end else begin
					exp_h = pending_hits.pop_front();
					check_field("hit_found", exp_h.hit, hit_ch.hit_found);
					check_field("distance", exp_h.hit_dist, hit_ch.distance);
					check_field("point_x", exp_h.pt[0], hit_ch.point_x);
					check_field("point_y", exp_h.pt[1], hit_ch.point_y);
					check_field("point_z", exp_h.pt[2], hit_ch.point_z);
					check_field("tex_u", exp_h.tu, hit_ch.tex_u);
					check_field("tex_v", exp_h.tv, hit_ch.tex_v);
				end
			end
			cycle_cnt++;
			if (cycle_cnt % 128 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: rdy = 1'b1;
				1: rdy = $urandom_range(0, 9) < 7;
				2: rdy = (cycle_cnt % 4) == 0;
				default: rdy = (cycle_cnt % 40) >= 25;
			endcase
			hit_ch.ready <= rdy;
		end
	end

	// Watchdog: cycles without any transaction on either channel or the APB port.
	always @(posedge clk) begin
		if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready) ||
			(psel && penable) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= AW'(idx) << AL; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// Register takes the value at this edge; mirror it
		case (idx)
			REG_V0_XYZ: vert_reg[0] = val[62:0];
			REG_V1_XYZ: vert_reg[1] = val[62:0];
			REG_V2_XYZ: vert_reg[2] = val[62:0];
			REG_V0_TEX: tex_reg[0] = val[31:0];
			REG_V1_TEX: tex_reg[1] = val[31:0];
			REG_V2_TEX: tex_reg[2] = val[31:0];
			REG_THRESH: thresh_reg = val[19:0];
			default: ;
		endcase
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	function automatic logic [63:0] pack_vertex(int x, int y, int z);
		return {1'b0, z[CW-1:0], y[CW-1:0], x[CW-1:0]};
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic set_triangle(logic [63:0] v0, logic [63:0] v1, logic [63:0] v2,
		logic [63:0] t0, logic [63:0] t1, logic [63:0] t2, logic [63:0] th);
		reg_write(REG_V0_XYZ, v0);
		reg_write(REG_V1_XYZ, v1);
		reg_write(REG_V2_XYZ, v2);
		reg_write(REG_V0_TEX, t0);
		reg_write(REG_V1_TEX, t1);
		reg_write(REG_V2_TEX, t2);
		reg_write(REG_THRESH, th);
	endtask

	task automatic add_ray(int ox, int oy, int oz, int dx, int dy, int dz, int nl, int fl);
		ray_item_t r;
		r.org[0] = coord_t'(ox); r.org[1] = coord_t'(oy); r.org[2] = coord_t'(oz);
		r.dir[0] = coord_t'(dx); r.dir[1] = coord_t'(dy); r.dir[2] = coord_t'(dz);
		r.near_l = nl; r.far_l = fl;
		ray_backlog.push_back(r);
	endtask

	task automatic add_noise_ray();
		ray_item_t r;
		for (int i = 0; i < 3; i++) begin
			r.org[i] = coord_t'($urandom());
			r.dir[i] = coord_t'($urandom());
		end
		r.near_l = $urandom();
		r.far_l = ($urandom_range(0, 3) == 0) ? TMAX : $urandom();
		ray_backlog.push_back(r);
	endtask

	// Aim a ray at a random point of the current triangle, t near k.
	task automatic add_aimed_ray();
		int     vc[3][3], b1, b2, k, pt, dr;
		coord_t c;
		ray_item_t r;
		for (int j = 0; j < 3; j++)
			for (int i = 0; i < 3; i++) begin
				c = vert_reg[j][i*CW +: CW];
				vc[j][i] = int'(c);
			end
		b1 = $urandom_range(0, 1024);
		b2 = $urandom_range(0, 1024 - b1);
		k = $urandom_range(1, 3);
		for (int i = 0; i < 3; i++) begin
			pt = vc[0][i] + ((b1 * (vc[1][i] - vc[0][i])) >>> 10)
				+ ((b2 * (vc[2][i] - vc[0][i])) >>> 10);
			dr = $urandom_range(0, 1 << 17) - (1 << 16);
			r.dir[i] = coord_t'(dr);
			r.org[i] = coord_t'(pt - k * dr);
		end
		case ($urandom_range(0, 3))
			0: r.near_l = TMIN;
			1: r.near_l = $urandom_range(0, 3 << 16) - (1 << 16);
			default: r.near_l = 0;
		endcase
		r.far_l = ($urandom_range(0, 1) == 0) ? TMAX : $urandom_range(1 << 16, 5 << 16);
		ray_backlog.push_back(r);
	endtask

	// Hold the next phase until every ray has produced its result.
	task automatic drain();
		while (ray_backlog.size() != 0 || ray_ch.valid || pending_hits.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic int rand_coord(int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	initial begin
		logic [63:0] th;
		errors = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		ray_ch.valid = 1'b0;
		ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
		ray_ch.direction_x = '0; ray_ch.direction_y = '0; ray_ch.direction_z = '0;
		ray_ch.near_limit = '0; ray_ch.far_limit = '0;
		hit_ch.ready = 1'b0;
		for (int i = 0; i < 3; i++) begin
			vert_reg[i] = '0;
			tex_reg[i] = '0;
		end
		thresh_reg = 20'd1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset triangle is degenerate: every ray misses
		for (int i = 0; i < 8; i++) add_noise_ray();
		drain();

		// Right triangle in the z = 0 plane, legs of 4.0 along x and y
		set_triangle(pack_vertex(0, 0, 0), pack_vertex(4096, 0, 0), pack_vertex(0, 4096, 0),
			64'h4000_0000, 64'h0000_8000, 64'hFFFF_7FFF, 64'd1);
		add_ray(1024, 1024, 1024, 0, 0, -1024, 0, TMAX);         // interior hit
		add_ray(0, 0, 1024, 0, 0, -1024, 0, TMAX);               // first vertex
		add_ray(4096, 0, 1024, 0, 0, -1024, 0, TMAX);            // second vertex
		add_ray(2048, 2048, 1024, 0, 0, -1024, 0, TMAX);         // on the u+v edge
		add_ray(4097, 0, 1024, 0, 0, -1024, 0, TMAX);            // u beyond one
		add_ray(100, -1, 1024, 0, 0, -1024, 0, TMAX);            // v below zero
		add_ray(-1, 100, 1024, 0, 0, -1024, 0, TMAX);            // u below zero
		add_ray(1024, 1024, 1024, 1024, 0, 0, TMIN, TMAX);       // parallel
		add_ray(1024, 1024, 1024, 0, 0, 0, TMIN, TMAX);          // zero direction
		add_ray(1024, 1024, -1024, 0, 0, -1024, 0, TMAX);        // behind origin
		add_ray(1024, 1024, -1024, 0, 0, -1024, TMIN, TMAX);     // negative t accepted
		add_ray(1024, 1024, 1024, 0, 0, -1024, 65536, TMAX);     // t equals near
		add_ray(1024, 1024, 1024, 0, 0, -1024, 0, 65536);        // t equals far
		add_ray(1024, 1024, 1024, 0, 0, -1024, 65535, 65537);    // tight window
		add_ray(1024, 1024, 1024, 0, 0, -1, 0, TMAX);            // large positive t
		add_ray(1024, 1024, 1024, 0, 0, -1, 0, TMAX - 1);        // large t vs far limit
		add_ray(1024, 1024, -1024, 0, 0, -1, TMIN, TMAX);        // large negative t
		add_ray(1024, 1024, 1048575, 1048575, 1048575, -1048576, TMIN, TMAX);
		add_ray(-1048576, -1048576, 1048575, 1048575, 1048575, -1048576, TMIN, TMAX);
		add_ray(1048575, 1048575, 1048575, 1048575, 1048575, 1048575, TMAX, TMAX);
		add_ray(-1048576, -1048576, -1048576, -1048576, -1048576, -1048576, TMIN, TMIN);
		add_ray(1024, 1024, 1048575, 0, 0, -1048576, TMIN, TMAX); // hit from the top of the z range
		drain();

		// Random triangles; threshold sweeps zero, one, random and maximum
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: th = 64'd0;
				1: th = 64'd1;
				2: th = $urandom_range(0, 1 << 12);
				default: th = 64'hFFFFF;
			endcase
			if (ph == 5)
				set_triangle(64'hFFFF_FFFF_FFFF_FFFF, rand64(), 64'h0, 64'hFFFF_FFFF,
					64'hFFFF_FFFF, 64'hFFFF_FFFF, th);
			else if (ph == 6)
				set_triangle(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
					rand64());
			else
				set_triangle({1'($urandom_range(0, 1)), 63'(pack_vertex(rand_coord(1 << 18),
					rand_coord(1 << 18), rand_coord(1 << 18)))},
					pack_vertex(rand_coord(1 << 18), rand_coord(1 << 18), rand_coord(1 << 18)),
					pack_vertex(rand_coord(1 << 18), rand_coord(1 << 18), rand_coord(1 << 18)),
					rand64(), rand64(), rand64(), th);
			for (int i = 0; i < 75; i++) begin
				if ($urandom_range(0, 4) == 0) add_noise_ray();
				else add_aimed_ray();
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
